### src/x87rs_pkg.sv
// package: types, codes and helpers for the x87 register stack unit
`default_nettype none
package x87rs_pkg;

   localparam logic [15:0] CW_DEFAULT = 16'h037f;
   localparam logic [63:0] INDEF_NAN  = 64'hfff8000000000000;
   localparam logic [15:0] SW_EXC_BITS = 16'h00ff;
   localparam logic [15:0] SW_BUSY = 16'h8000;
   localparam logic [15:0] SW_IE = 16'h0001;
   localparam logic [15:0] SW_SF = 16'h0040;
   localparam logic [15:0] SW_C1 = 16'h0200;

   typedef enum logic [4:0] {
      OP_INIT = 5'd0, OP_CLEX = 5'd1, OP_INCSTP = 5'd2, OP_DECSTP = 5'd3,
      OP_XAM = 5'd4, OP_PUSH = 5'd5, OP_POP = 5'd6, OP_FPOP = 5'd7,
      OP_READ = 5'd8, OP_SET = 5'd9, OP_STORE = 5'd10, OP_UNDER = 5'd11,
      OP_COM = 5'd12, OP_TST = 5'd13, OP_CHS = 5'd14, OP_ABS = 5'd15,
      OP_RNDINT = 5'd16, OP_FIST = 5'd17, OP_FISTP = 5'd18, OP_NOP = 5'd19
   } op_type;

   typedef enum logic [1:0] {
      RC_OK = 2'd0, RC_BADARG = 2'd1, RC_FAULT = 2'd2
   } code_type;

   typedef struct packed {
      logic [4:0]  mode;
      logic [2:0]  stack_index;
      logic [63:0] operand_bits;
      logic [1:0]  int_size;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_code;
      logic [63:0] data_out;
      logic [15:0] fpu_sw;
      logic [15:0] slot_tag_bits;
   } rsp_type;

   function automatic logic [1:0] class_tag(input logic [63:0] b);
      if (b[62:52] == 11'd0 && b[51:0] == 52'd0) return 2'd1;
      if (b[62:52] == 11'h7ff || b[62:52] == 11'd0) return 2'd2;
      return 2'd0;
   endfunction

   function automatic logic is_nan(input logic [63:0] b);
      return b[62:52] == 11'h7ff && b[51:0] != 52'd0;
   endfunction

   // round a double to an integral double under rounding control rc
   function automatic logic [63:0] round_bits(input logic [63:0] b, input logic [1:0] rc);
      logic        neg;
      logic [10:0] e;
      logic [5:0]  fb;
      logic [63:0] mask;
      logic [63:0] frac;
      logic [63:0] tm;
      logic [63:0] half;
      logic        inc;
      logic        one;
      neg = b[63];
      e = b[62:52];
      fb = 6'(11'd1075 - e);
      mask = (64'd1 << fb) - 64'd1;
      frac = {1'b0, b[62:0]} & mask;
      tm = {1'b0, b[62:0]} & ~mask;
      half = 64'd1 << (fb - 6'd1);
      inc = 1'b0;
      one = 1'b0;
      if (e == 11'h7ff) return is_nan(b) ? (b | (64'd1 << 51)) : b;
      if (b[62:0] == 63'd0 || e >= 11'd1075) return b;
      if (e < 11'd1023) begin
         case (rc)
            2'd0: one = (e == 11'd1022) && (b[51:0] != 52'd0);
            2'd1: one = neg;
            2'd2: one = !neg;
            default: one = 1'b0;
         endcase
         return {neg, (one ? 63'h3ff0000000000000 : 63'd0)};
      end
      if (frac == 64'd0) return b;
      case (rc)
         2'd0: inc = frac > half || (frac == half && (tm & (64'd1 << fb)) != 64'd0);
         2'd1: inc = neg;
         2'd2: inc = !neg;
         default: inc = 1'b0;
      endcase
      if (inc) tm = tm + (64'd1 << fb);
      return {neg, tm[62:0]};
   endfunction

endpackage
`default_nettype wire

### src/x87_register_stack_unit.sv
// top level: eight-slot x87 register stack with tags and status word
// the result is registered: rsp_valid rises in the cycle after start; throughput: one item every cycle
// busy is tied low, so an item may be taken at every clock edge
// the whole operation is one combinational pass from the stack registers to the result
// reset (synchronous): values zero, all tags empty, top zero, status zero, cw 0x037f
// the receiver cannot stall; each result is shown for exactly one cycle
`default_nettype none
module x87_register_stack_unit (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output      logic                busy,
   input  wire x87rs_pkg::req_type  req_item,
   output      logic                rsp_valid,
   output      x87rs_pkg::rsp_type  rsp_item,
   input  wire logic                csr_write,
   input  wire logic [15:0]         csr_data
);

   logic [63:0] slot_ff [8];
   logic [63:0] slot_in [8];
   logic [15:0] tag_ff, tag_in;
   logic [2:0]  top_ff, top_in;
   logic [15:0] sw_ff, sw_in;
   logic [15:0] cw_ff, cw_in;
   logic        valid_ff;
   x87rs_pkg::rsp_type rsp_ff, rsp_in;

   assign busy = 1'b0;
   assign rsp_valid = valid_ff;
   assign rsp_item = rsp_ff;

   // integer conversion pieces
   logic [63:0] rnd;
   logic [10:0] re;
   logic [5:0]  rk;
   logic [52:0] rsig;
   logic [63:0] mag, lim, ival;
   logic        int_ok;

   always_comb begin
      rnd = x87rs_pkg::round_bits(slot_ff[top_ff], cw_ff[11:10]);
      re = rnd[62:52];
      rk = 6'(re - 11'd1023);
      rsig = {1'b1, rnd[51:0]};
      int_ok = 1'b1;
      mag = 64'd0;
      if (re == 11'h7ff) int_ok = 1'b0;
      else if (re < 11'd1023) mag = 64'd0;
      else if (re > 11'd1086) int_ok = 1'b0;
      else if (re == 11'd1086) begin
         if (!(rnd[63] && rnd[51:0] == 52'd0)) int_ok = 1'b0;
         mag = 64'h8000000000000000;
      end else if (rk >= 6'd52) mag = {11'd0, rsig} << (rk - 6'd52);
      else mag = {11'd0, rsig} >> (6'd52 - rk);
      case (req_item.int_size)
         2'd0: lim = 64'd1 << 15;
         2'd1: lim = 64'd1 << 31;
         default: lim = 64'd1 << 63;
      endcase
      if (rnd[63] ? mag > lim : mag >= lim) int_ok = 1'b0;
      ival = rnd[63] ? (64'd0 - mag) : mag;
   end

   logic [2:0]  phys, tdn, tup;
   logic        e0, ep, en;
   logic [63:0] v0, nv;
   logic        lt, eq, un;

   always_comb begin
      phys = top_ff + req_item.stack_index;
      tdn = top_ff - 3'd1;
      tup = top_ff + 3'd1;
      e0 = tag_ff[{top_ff, 1'b0} +: 2] == 2'd3;
      ep = tag_ff[{phys, 1'b0} +: 2] == 2'd3;
      en = tag_ff[{tdn, 1'b0} +: 2] == 2'd3;
      v0 = slot_ff[top_ff];
      nv = (req_item.mode == x87rs_pkg::OP_COM) ? req_item.operand_bits : 64'd0;
      un = x87rs_pkg::is_nan(v0) || x87rs_pkg::is_nan(nv);
      // ieee compare on sign-magnitude bits, zeros of both signs equal
      eq = (v0 == nv) || (v0[62:0] == 63'd0 && nv[62:0] == 63'd0);
      if (eq) lt = 1'b0;
      else if (v0[63] != nv[63]) lt = v0[63];
      else lt = v0[63] ? (v0[62:0] > nv[62:0]) : (v0[62:0] < nv[62:0]);
   end

   always_comb begin
      slot_in = slot_ff;
      tag_in = tag_ff;
      top_in = top_ff;
      sw_in = sw_ff;
      cw_in = csr_write ? csr_data : cw_ff;
      rsp_in.result_code = x87rs_pkg::RC_OK;
      rsp_in.data_out = 64'd0;
      if (start) begin
         case (req_item.mode)
            x87rs_pkg::OP_INIT: begin
               for (int i = 0; i < 8; i++) slot_in[i] = 64'd0;
               tag_in = 16'hffff;
               top_in = 3'd0;
               sw_in = 16'd0;
               cw_in = x87rs_pkg::CW_DEFAULT;
            end
            x87rs_pkg::OP_CLEX: sw_in = sw_ff & ~(x87rs_pkg::SW_EXC_BITS | x87rs_pkg::SW_BUSY);
            x87rs_pkg::OP_INCSTP: top_in = tup;
            x87rs_pkg::OP_DECSTP: top_in = tdn;
            x87rs_pkg::OP_XAM: begin
               sw_in[9] = !e0 && v0[63];
               if (e0) {sw_in[14], sw_in[10], sw_in[8]} = 3'b101;
               else if (x87rs_pkg::is_nan(v0)) {sw_in[14], sw_in[10], sw_in[8]} = 3'b001;
               else if (v0[62:52] == 11'h7ff) {sw_in[14], sw_in[10], sw_in[8]} = 3'b011;
               else if (v0[62:0] == 63'd0) {sw_in[14], sw_in[10], sw_in[8]} = 3'b100;
               else if (v0[62:52] == 11'd0) {sw_in[14], sw_in[10], sw_in[8]} = 3'b110;
               else {sw_in[14], sw_in[10], sw_in[8]} = 3'b010;
            end
            x87rs_pkg::OP_PUSH: begin
               if (!en) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else begin
                  top_in = tdn;
                  slot_in[tdn] = req_item.operand_bits;
                  tag_in[{tdn, 1'b0} +: 2] = x87rs_pkg::class_tag(req_item.operand_bits);
               end
            end
            x87rs_pkg::OP_POP, x87rs_pkg::OP_FPOP: begin
               if (e0 && req_item.mode == x87rs_pkg::OP_POP)
                  rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else begin
                  tag_in[{top_ff, 1'b0} +: 2] = 2'd3;
                  top_in = tup;
               end
            end
            x87rs_pkg::OP_READ: begin
               if (ep) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else rsp_in.data_out = slot_ff[phys];
            end
            x87rs_pkg::OP_SET, x87rs_pkg::OP_STORE: begin
               if (ep && req_item.mode == x87rs_pkg::OP_SET)
                  rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else begin
                  slot_in[phys] = req_item.operand_bits;
                  tag_in[{phys, 1'b0} +: 2] = x87rs_pkg::class_tag(req_item.operand_bits);
               end
            end
            x87rs_pkg::OP_UNDER: begin
               sw_in = (sw_ff | x87rs_pkg::SW_IE | x87rs_pkg::SW_SF) & ~x87rs_pkg::SW_C1;
               if (!cw_ff[0]) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else rsp_in.data_out = x87rs_pkg::INDEF_NAN;
            end
            x87rs_pkg::OP_COM, x87rs_pkg::OP_TST: begin
               if (e0) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else {sw_in[14], sw_in[10], sw_in[8]} = un ? 3'b111 : {eq, 1'b0, lt};
            end
            x87rs_pkg::OP_CHS, x87rs_pkg::OP_ABS, x87rs_pkg::OP_RNDINT: begin
               if (e0) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else begin
                  case (req_item.mode)
                     x87rs_pkg::OP_CHS: slot_in[top_ff] = {~v0[63], v0[62:0]};
                     x87rs_pkg::OP_ABS: slot_in[top_ff] = {1'b0, v0[62:0]};
                     default: slot_in[top_ff] = rnd;
                  endcase
                  tag_in[{top_ff, 1'b0} +: 2] = x87rs_pkg::class_tag(slot_in[top_ff]);
               end
            end
            x87rs_pkg::OP_FIST, x87rs_pkg::OP_FISTP: begin
               if (req_item.int_size == 2'd3) rsp_in.result_code = x87rs_pkg::RC_BADARG;
               else if (e0 || !int_ok) rsp_in.result_code = x87rs_pkg::RC_FAULT;
               else begin
                  rsp_in.data_out = ival;
                  if (req_item.mode == x87rs_pkg::OP_FISTP) begin
                     tag_in[{top_ff, 1'b0} +: 2] = 2'd3;
                     top_in = tup;
                  end
               end
            end
            x87rs_pkg::OP_NOP: ;
            default: rsp_in.result_code = x87rs_pkg::RC_BADARG;
         endcase
         sw_in[13:11] = top_in;
      end
      rsp_in.fpu_sw = sw_in;
      rsp_in.slot_tag_bits = tag_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) slot_ff[i] <= 64'd0;
         tag_ff <= 16'hffff;
         top_ff <= 3'd0;
         sw_ff <= 16'd0;
         cw_ff <= x87rs_pkg::CW_DEFAULT;
         valid_ff <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         tag_ff <= tag_in;
         top_ff <= top_in;
         sw_ff <= sw_in;
         cw_ff <= cw_in;
         valid_ff <= start;
      end
      rsp_ff <= rsp_in;
   end

   // top field of the status word tracks the top pointer
   a_top_sync: assert property (@(posedge clock) disable iff (reset)
      sw_ff[13:11] == top_ff) else $error("status top out of sync");
   // one result per accepted item, in the cycle after it
   a_one_rsp: assert property (@(posedge clock) disable iff (reset)
      start |=> rsp_valid) else $error("missing result");
   // a faulting push leaves the top pointer alone
   a_push_fault: assert property (@(posedge clock) disable iff (reset)
      start && req_item.mode == x87rs_pkg::OP_PUSH && !en |=> $stable(top_ff))
      else $error("faulting push moved top");

endmodule
`default_nettype wire
